### rtl/core/sdi_pkg.sv
// Shared types and constants for the SD card bring-up sequencer.
// Holds event/action/error codes, datapath operations, command words
// and the controller <-> datapath command and status structs.
package sdi_pkg;

   // event kinds on the request side
   typedef enum logic [2:0] {
      REQ_START      = 3'd0,
      REQ_HRST_DONE  = 3'd1,
      REQ_CLK_STABLE = 3'd2,
      REQ_CMD_DONE   = 3'd3,
      REQ_FAILURE    = 3'd4,
      REQ_RETRY_TICK = 3'd5,
      REQ_ACCESS     = 3'd6,
      REQ_RSVD       = 3'd7
   } req_kind_type;

   // action codes on the response side
   localparam logic [2:0] ACT_NONE       = 3'd0;
   localparam logic [2:0] ACT_RESET_HOST = 3'd1;
   localparam logic [2:0] ACT_SET_CLOCK  = 3'd2;
   localparam logic [2:0] ACT_ISSUE      = 3'd3;
   localparam logic [2:0] ACT_WAIT_RETRY = 3'd4;
   localparam logic [2:0] ACT_READY      = 3'd5;
   localparam logic [2:0] ACT_FAILED     = 3'd6;
   localparam logic [2:0] ACT_DONE       = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_CLOCK    = 3'd1;
   localparam logic [2:0] ERR_CMD      = 3'd2;
   localparam logic [2:0] ERR_POWER    = 3'd3;
   localparam logic [2:0] ERR_NOT_INIT = 3'd4;

   // command-and-transfer-mode words
   localparam logic [31:0] CMD0_WORD   = 32'h0000_0000;
   localparam logic [31:0] CMD2_WORD   = 32'h0209_0000;
   localparam logic [31:0] CMD3_WORD   = 32'h030A_0000;
   localparam logic [31:0] CMD7_WORD   = 32'h070B_0000;
   localparam logic [31:0] CMD8_WORD   = 32'h081A_0000;
   localparam logic [31:0] CMD16_WORD  = 32'h100A_0000;
   localparam logic [31:0] CMD17_WORD  = 32'h112A_0012;
   localparam logic [31:0] CMD24_WORD  = 32'h182A_0002;
   localparam logic [31:0] CMD55_WORD  = 32'h370A_0000;
   localparam logic [31:0] ACMD41_WORD = 32'h2902_0000;

   localparam logic [31:0] CMD8_ARG    = 32'h0000_01AA;
   localparam logic [11:0] CMD8_ECHO   = 12'h1AA;
   localparam logic [31:0] ACMD41_ARG  = 32'h00FF_8000;
   localparam int          BLOCK_BYTES = 512;
   localparam int          BLOCK_SHIFT = $clog2(BLOCK_BYTES);
   localparam logic [31:0] CMD16_ARG   = 32'(BLOCK_BYTES);

   // clock divider
   localparam logic [29:0] BASE_MIN      = 30'd1_000_000;
   localparam logic [29:0] BASE_MAX      = 30'd1_000_000_000;
   localparam logic [29:0] BASE_FALLBACK = 30'd41_666_666;
   localparam logic [9:0]  DIV_MAX       = 10'h3FF;
   localparam int          DIV_NUM_W     = 31;
   localparam int          DIV_DEN_W     = 27;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_START,
      OP_CLK_ID,
      OP_CMD0,
      OP_CMD7,
      OP_CMD8,
      OP_CMD8_DONE,
      OP_CMD8_FAIL,
      OP_CMD55,
      OP_ACMD41,
      OP_POWER_OK,
      OP_POWER_FAIL,
      OP_POWER_WAIT,
      OP_CMD3,
      OP_CLK_WORK,
      OP_CMD16,
      OP_READY,
      OP_ACCESS,
      OP_ACCESS_DONE,
      OP_FAIL_CMD,
      OP_FAIL_HOST,
      OP_FAIL_CLK,
      OP_NOT_INIT
   } op_type;

   typedef struct packed {
      logic   load;       // latch the accepted word's payload
      logic   div_start;  // launch the divider
      logic   div_work;   // 1: working clock, 0: identification clock
      logic   commit;     // apply op to state and result register
      op_type op;
   } sdi_cmd_type;

   typedef struct packed {
      logic div_done;
      logic pwr_ready;  // ACMD41 response has the busy/ready bit set
      logic pwr_limit;  // next try count reaches the limit
   } sdi_stat_type;

endpackage

### rtl/core/sdi_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on sdi_pkg for the operand widths.
module sdi_divider
   import sdi_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic [DIV_NUM_W-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NUM_W);
   localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_NUM_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   assign trial = {rem_ff, quo_ff[DIV_NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         den_in  = den;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         quo_in = {quo_ff[DIV_NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_done_idle : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

endmodule

### rtl/core/sdi_datapath.sv
// Datapath: payload latch, card state, divider and result register.
// Depends on sdi_pkg and sdi_divider; driven by sdi_ctrl commands.
module sdi_datapath
   import sdi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  sdi_cmd_type  cmd,
   output sdi_stat_type stat,
   input  logic [31:0]  resp_word,
   input  logic         is_write,
   input  logic [31:0]  block_lba,
   input  logic [29:0]  base_clock_hz,
   input  logic [18:0]  ident_clock_hz,
   input  logic [25:0]  work_clock_hz,
   input  logic [9:0]   max_power_tries,
   output logic [2:0]   action,
   output logic [31:0]  cmd_word,
   output logic [31:0]  cmd_arg,
   output logic [9:0]   clock_divider,
   output logic [2:0]   error_code,
   output logic [5:0]   failed_cmd,
   output logic         cmd_line_reset,
   output logic         block_addressed,
   output logic [15:0]  card_rca
);

   // payload latch
   logic [31:0] resp_ff;
   logic        wr_ff;
   logic [31:0] lba_ff;

   // card state
   logic        v2_ff, v2_in;
   logic        hc_ff, hc_in;
   logic [15:0] rca_ff, rca_in;
   logic [9:0]  try_ff, try_in;
   logic [5:0]  pend_ff, pend_in;
   logic [9:0]  divr_ff, divr_in;

   // result register
   logic [2:0]  act_ff, act_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] arg_ff, arg_in;
   logic [2:0]  err_ff, err_in;
   logic [5:0]  fcmd_ff, fcmd_in;
   logic        clr_ff, clr_in;

   logic [9:0]           try_inc;
   logic [25:0]          hz;
   logic [29:0]          base_eff;
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic [DIV_NUM_W-1:0] quo;
   logic [9:0]           quo_clamp;
   logic                 div_busy;
   logic                 iss;
   logic [31:0]          rca_arg;
   logic [31:0]          lba_arg;

   assign try_inc = try_ff + 1'b1;
   assign rca_arg = {rca_ff, 16'h0000};
   assign lba_arg = hc_ff ? lba_ff : {lba_ff[31-BLOCK_SHIFT:0], BLOCK_SHIFT'(0)};

   assign stat.pwr_ready = resp_ff[31];
   assign stat.pwr_limit = try_inc >= max_power_tries;

   // ceil(base / 2hz) = floor((base + 2hz - 1) / 2hz); hz of zero gives all ones
   assign hz       = cmd.div_work ? work_clock_hz : 26'(ident_clock_hz);
   assign base_eff = (base_clock_hz < BASE_MIN || base_clock_hz > BASE_MAX) ?
                     BASE_FALLBACK : base_clock_hz;
   assign div_den  = {hz, 1'b0};
   assign div_num  = DIV_NUM_W'({1'b0, base_eff} + {4'b0, div_den} - 31'd1);

   sdi_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (stat.div_done),
      .quo   (quo)
   );

   always_comb begin
      if (quo == '0)
         quo_clamp = 10'd1;
      else if (quo > DIV_NUM_W'(DIV_MAX))
         quo_clamp = DIV_MAX;
      else
         quo_clamp = quo[9:0];
   end

   always_comb begin
      v2_in   = v2_ff;
      hc_in   = hc_ff;
      rca_in  = rca_ff;
      try_in  = try_ff;
      pend_in = pend_ff;
      divr_in = divr_ff;
      act_in  = ACT_NONE;
      word_in = '0;
      arg_in  = '0;
      err_in  = ERR_NONE;
      fcmd_in = '0;
      clr_in  = 1'b0;
      iss     = 1'b0;
      case (cmd.op)
         OP_START: begin
            v2_in   = 1'b0;
            hc_in   = 1'b0;
            rca_in  = '0;
            try_in  = '0;
            pend_in = '0;
            act_in  = ACT_RESET_HOST;
         end
         OP_CLK_ID, OP_CLK_WORK: begin
            if (cmd.op == OP_CLK_WORK)
               rca_in = resp_ff[31:16];
            divr_in = quo_clamp;
            act_in  = ACT_SET_CLOCK;
         end
         OP_CMD0: begin
            iss     = 1'b1;
            word_in = CMD0_WORD;
         end
         OP_CMD7: begin
            iss     = 1'b1;
            word_in = CMD7_WORD;
            arg_in  = rca_arg;
         end
         OP_CMD8: begin
            iss     = 1'b1;
            word_in = CMD8_WORD;
            arg_in  = CMD8_ARG;
         end
         OP_CMD8_DONE, OP_CMD8_FAIL: begin
            v2_in   = (cmd.op == OP_CMD8_DONE) && (resp_ff[11:0] == CMD8_ECHO);
            clr_in  = cmd.op == OP_CMD8_FAIL;
            try_in  = '0;
            iss     = 1'b1;
            word_in = CMD55_WORD;
            arg_in  = rca_arg;
         end
         OP_CMD55: begin
            iss     = 1'b1;
            word_in = CMD55_WORD;
            arg_in  = rca_arg;
         end
         OP_ACMD41: begin
            iss     = 1'b1;
            word_in = ACMD41_WORD;
            arg_in  = ACMD41_ARG | {1'b0, v2_ff, 30'h0};
         end
         OP_POWER_OK: begin
            try_in  = try_inc;
            hc_in   = resp_ff[30];
            iss     = 1'b1;
            word_in = CMD2_WORD;
         end
         OP_POWER_FAIL: begin
            try_in  = try_inc;
            act_in  = ACT_FAILED;
            err_in  = ERR_POWER;
            fcmd_in = pend_ff;
         end
         OP_POWER_WAIT: begin
            try_in = try_inc;
            act_in = ACT_WAIT_RETRY;
         end
         OP_CMD3: begin
            iss     = 1'b1;
            word_in = CMD3_WORD;
         end
         OP_CMD16: begin
            iss     = 1'b1;
            word_in = CMD16_WORD;
            arg_in  = CMD16_ARG;
         end
         OP_READY:       act_in = ACT_READY;
         OP_ACCESS: begin
            iss     = 1'b1;
            word_in = wr_ff ? CMD24_WORD : CMD17_WORD;
            arg_in  = lba_arg;
         end
         OP_ACCESS_DONE: act_in = ACT_DONE;
         OP_FAIL_CMD, OP_FAIL_HOST, OP_FAIL_CLK: begin
            act_in  = ACT_FAILED;
            err_in  = (cmd.op == OP_FAIL_CLK) ? ERR_CLOCK : ERR_CMD;
            fcmd_in = pend_ff;
            clr_in  = cmd.op == OP_FAIL_CMD;
         end
         OP_NOT_INIT: begin
            act_in = ACT_FAILED;
            err_in = ERR_NOT_INIT;
         end
         default: ;
      endcase
      if (iss) begin
         act_in  = ACT_ISSUE;
         pend_in = word_in[29:24];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         resp_ff <= resp_word;
         wr_ff   <= is_write;
         lba_ff  <= block_lba;
      end
      if (reset) begin
         v2_ff   <= 1'b0;
         hc_ff   <= 1'b0;
         rca_ff  <= '0;
         try_ff  <= '0;
         pend_ff <= '0;
         divr_ff <= '0;
      end else if (cmd.commit) begin
         v2_ff   <= v2_in;
         hc_ff   <= hc_in;
         rca_ff  <= rca_in;
         try_ff  <= try_in;
         pend_ff <= pend_in;
         divr_ff <= divr_in;
      end
      if (cmd.commit) begin
         act_ff  <= act_in;
         word_ff <= word_in;
         arg_ff  <= arg_in;
         err_ff  <= err_in;
         fcmd_ff <= fcmd_in;
         clr_ff  <= clr_in;
      end
   end

   // card state changes only on commit, so it matches the word on the output
   assign action          = act_ff;
   assign cmd_word        = word_ff;
   assign cmd_arg         = arg_ff;
   assign clock_divider   = divr_ff;
   assign error_code      = err_ff;
   assign failed_cmd      = fcmd_ff;
   assign cmd_line_reset  = clr_ff;
   assign block_addressed = hc_ff;
   assign card_rca        = rca_ff;

   a_no_commit_busy : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !div_busy)
      else $error("commit while divider running");

endmodule

### rtl/core/sdi_ctrl.sv
// Controller: bring-up phase machine and per-word handshake sequencing.
// Depends on sdi_pkg; commands sdi_datapath through sdi_cmd_type.
module sdi_ctrl
   import sdi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_type,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output sdi_cmd_type  cmd,
   input  sdi_stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_COMMIT
   } eng_type;

   typedef enum logic [4:0] {
      PH_IDLE, PH_HRST, PH_CLK_ID, PH_CMD0, PH_CMD8, PH_CMD55, PH_ACMD41,
      PH_RETRY, PH_CMD2, PH_CMD3, PH_CLK_WORK, PH_CMD7, PH_CMD16, PH_READY,
      PH_ACCESS, PH_FAILED
   } phase_type;

   eng_type      st_ff, st_in;
   phase_type    ph_ff, ph_in;
   phase_type    nph_ff, nph_in;
   op_type       op_ff, op_in;
   req_kind_type req_ff, req_in;
   logic         vld_ff, vld_in;
   logic         accept;
   logic         slot_free;
   logic         commit;
   logic         cmd_phase;
   op_type       dec_op;
   phase_type    dec_ph;

   assign accept    = req_tvalid && (st_ff == ST_IDLE);
   assign slot_free = !vld_ff || rsp_tready;
   assign commit    = (st_ff == ST_COMMIT) && slot_free;

   assign cmd_phase = (ph_ff == PH_CMD0) || (ph_ff == PH_CMD8) || (ph_ff == PH_CMD55) ||
                      (ph_ff == PH_ACMD41) || (ph_ff == PH_CMD2) || (ph_ff == PH_CMD3) ||
                      (ph_ff == PH_CMD7) || (ph_ff == PH_CMD16);

   // event x phase decode
   always_comb begin
      dec_op = OP_NONE;
      dec_ph = ph_ff;
      unique case (req_ff)
         REQ_START: begin
            dec_op = OP_START;
            dec_ph = PH_HRST;
         end
         REQ_HRST_DONE:
            if (ph_ff == PH_HRST) begin
               dec_op = OP_CLK_ID;
               dec_ph = PH_CLK_ID;
            end
         REQ_CLK_STABLE:
            if (ph_ff == PH_CLK_ID) begin
               dec_op = OP_CMD0;
               dec_ph = PH_CMD0;
            end else if (ph_ff == PH_CLK_WORK) begin
               dec_op = OP_CMD7;
               dec_ph = PH_CMD7;
            end
         REQ_CMD_DONE:
            case (ph_ff)
               PH_CMD0: begin
                  dec_op = OP_CMD8;
                  dec_ph = PH_CMD8;
               end
               PH_CMD8: begin
                  dec_op = OP_CMD8_DONE;
                  dec_ph = PH_CMD55;
               end
               PH_CMD55: begin
                  dec_op = OP_ACMD41;
                  dec_ph = PH_ACMD41;
               end
               PH_ACMD41:
                  if (stat.pwr_ready) begin
                     dec_op = OP_POWER_OK;
                     dec_ph = PH_CMD2;
                  end else if (stat.pwr_limit) begin
                     dec_op = OP_POWER_FAIL;
                     dec_ph = PH_FAILED;
                  end else begin
                     dec_op = OP_POWER_WAIT;
                     dec_ph = PH_RETRY;
                  end
               PH_CMD2: begin
                  dec_op = OP_CMD3;
                  dec_ph = PH_CMD3;
               end
               PH_CMD3: begin
                  dec_op = OP_CLK_WORK;
                  dec_ph = PH_CLK_WORK;
               end
               PH_CMD7: begin
                  dec_op = OP_CMD16;
                  dec_ph = PH_CMD16;
               end
               PH_CMD16: begin
                  dec_op = OP_READY;
                  dec_ph = PH_READY;
               end
               PH_ACCESS: begin
                  dec_op = OP_ACCESS_DONE;
                  dec_ph = PH_READY;
               end
               default: ;
            endcase
         REQ_FAILURE:
            if (ph_ff == PH_CMD8) begin
               // CMD8 timeout just means a v1 card
               dec_op = OP_CMD8_FAIL;
               dec_ph = PH_CMD55;
            end else if (cmd_phase) begin
               dec_op = OP_FAIL_CMD;
               dec_ph = PH_FAILED;
            end else if (ph_ff == PH_ACCESS) begin
               dec_op = OP_FAIL_CMD;
               dec_ph = PH_READY;
            end else if (ph_ff == PH_HRST) begin
               dec_op = OP_FAIL_HOST;
               dec_ph = PH_FAILED;
            end else if (ph_ff == PH_CLK_ID || ph_ff == PH_CLK_WORK) begin
               dec_op = OP_FAIL_CLK;
               dec_ph = PH_FAILED;
            end
         REQ_RETRY_TICK:
            if (ph_ff == PH_RETRY) begin
               dec_op = OP_CMD55;
               dec_ph = PH_CMD55;
            end
         REQ_ACCESS:
            if (ph_ff == PH_READY) begin
               dec_op = OP_ACCESS;
               dec_ph = PH_ACCESS;
            end else begin
               dec_op = OP_NOT_INIT;
            end
         REQ_RSVD: ;
         default: ;
      endcase
   end

   always_comb begin
      st_in  = st_ff;
      ph_in  = ph_ff;
      nph_in = nph_ff;
      op_in  = op_ff;
      req_in = req_ff;
      vld_in = vld_ff;
      if (rsp_tready)
         vld_in = 1'b0;
      unique case (st_ff)
         ST_IDLE:
            if (accept) begin
               req_in = req_kind_type'(req_type);
               st_in  = ST_DECODE;
            end
         ST_DECODE: begin
            op_in  = dec_op;
            nph_in = dec_ph;
            st_in  = (dec_op == OP_CLK_ID || dec_op == OP_CLK_WORK) ? ST_DIV : ST_COMMIT;
         end
         ST_DIV:
            if (stat.div_done)
               st_in = ST_COMMIT;
         ST_COMMIT:
            if (slot_free) begin
               ph_in  = nph_ff;
               vld_in = 1'b1;
               st_in  = ST_IDLE;
            end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         ph_ff  <= PH_IDLE;
         nph_ff <= PH_IDLE;
         op_ff  <= OP_NONE;
         req_ff <= REQ_RSVD;
         vld_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         ph_ff  <= ph_in;
         nph_ff <= nph_in;
         op_ff  <= op_in;
         req_ff <= req_in;
         vld_ff <= vld_in;
      end
   end

   assign req_tready    = st_ff == ST_IDLE;
   assign rsp_tvalid    = vld_ff;
   assign cmd.load      = accept;
   assign cmd.div_start = (st_ff == ST_DECODE) && (dec_op == OP_CLK_ID || dec_op == OP_CLK_WORK);
   assign cmd.div_work  = dec_op == OP_CLK_WORK;
   assign cmd.commit    = commit;
   assign cmd.op        = op_ff;

   a_commit_slot : assert property (@(posedge clock) disable iff (reset)
      commit |-> (!vld_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken while one is in work");

   a_commit_valid : assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_tvalid)
      else $error("committed result not presented");

endmodule

### rtl/core/sd_card_init_sequencer.sv
// SD card bring-up sequencer, top level: CSR block and controller/datapath.
// Depends on sdi_pkg, sdi_ctrl, sdi_datapath (which holds sdi_divider).
//
//   channel  dir  handshake          payload
//   req_     in   tvalid/tready      tuser: req_type; tdata: event payload
//   rsp_     out  tvalid/tready      tuser: action; tdata: result fields
//   csr_     in   APB psel/penable   4 x 32-bit registers at 4*i
//
// One event in, one result out. An accepted word passes through decode and commit states
// before rsp_tvalid rises, with a divide state between them for a set-clock event, where
// the 31-step serial divider runs; commit waits until the previous result is taken. A new
// word is taken once the previous result is in the output register, so a stalled rsp_
// side blocks at most one further word.
// reset is synchronous, active high, and puts the card phase to idle.
module sd_card_init_sequencer
   import sdi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [2:0]   req_tuser,   // req_type
   input  logic [71:0]  req_tdata,   // resp_word, is_write, block_lba, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [2:0]   rsp_tuser,   // action
   output logic [103:0] rsp_tdata,   // cmd_word, cmd_arg, clock_divider, error_code,
                                     // failed_cmd, cmd_line_reset, block_addressed,
                                     // card_rca, zero pad
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   localparam logic [1:0] CSR_BASE  = 2'd0;
   localparam logic [1:0] CSR_IDENT = 2'd1;
   localparam logic [1:0] CSR_WORK  = 2'd2;
   localparam logic [1:0] CSR_TRIES = 2'd3;

   logic [29:0] base_ff;
   logic [18:0] ident_ff;
   logic [25:0] work_ff;
   logic [9:0]  tries_ff;
   logic        csr_wr;

   sdi_cmd_type  cmd;
   sdi_stat_type stat;

   logic [31:0] cmd_word, cmd_arg;
   logic [9:0]  clock_divider;
   logic [2:0]  error_code;
   logic [5:0]  failed_cmd;
   logic        cmd_line_reset, block_addressed;
   logic [15:0] card_rca;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_FALLBACK;
         ident_ff <= 19'd400_000;
         work_ff  <= 26'd25_000_000;
         tries_ff <= 10'd1000;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            CSR_BASE:  base_ff  <= csr_pwdata[29:0];
            CSR_IDENT: ident_ff <= csr_pwdata[18:0];
            CSR_WORK:  work_ff  <= csr_pwdata[25:0];
            CSR_TRIES: tries_ff <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_BASE:  csr_prdata = {2'b0, base_ff};
         CSR_IDENT: csr_prdata = {13'b0, ident_ff};
         CSR_WORK:  csr_prdata = {6'b0, work_ff};
         CSR_TRIES: csr_prdata = {22'b0, tries_ff};
         default:   csr_prdata = '0;
      endcase
   end

   sdi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_type   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   sdi_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .resp_word       (req_tdata[31:0]),
      .is_write        (req_tdata[32]),
      .block_lba       (req_tdata[64:33]),
      .base_clock_hz   (base_ff),
      .ident_clock_hz  (ident_ff),
      .work_clock_hz   (work_ff),
      .max_power_tries (tries_ff),
      .action          (rsp_tuser),
      .cmd_word        (cmd_word),
      .cmd_arg         (cmd_arg),
      .clock_divider   (clock_divider),
      .error_code      (error_code),
      .failed_cmd      (failed_cmd),
      .cmd_line_reset  (cmd_line_reset),
      .block_addressed (block_addressed),
      .card_rca        (card_rca)
   );

   assign rsp_tdata = {3'b0, card_rca, block_addressed, cmd_line_reset, failed_cmd,
                       error_code, clock_divider, cmd_arg, cmd_word};

endmodule

### bench/tb_top.sv
// Self-checking bench for sd_card_init_sequencer: directed bring-up and failure
// cases, then random event traffic checked against an in-bench sequencer model.
// Depends on sdi_pkg for the event, action and error codes.
module tb_top
   import sdi_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 2000;
   localparam int SECTOR_BYTES = 512;

   // register indexes
   localparam logic [1:0] CSR_BASE_HZ   = 2'd0;
   localparam logic [1:0] CSR_IDENT_HZ  = 2'd1;
   localparam logic [1:0] CSR_WORK_HZ   = 2'd2;
   localparam logic [1:0] CSR_MAX_TRIES = 2'd3;

   // command word fields
   localparam logic [31:0] F_DATA   = 32'h0020_0000;
   localparam logic [31:0] F_IXCHK  = 32'h0010_0000;
   localparam logic [31:0] F_CRCCHK = 32'h0008_0000;
   localparam logic [31:0] R_136    = 32'h0001_0000;
   localparam logic [31:0] R_48     = 32'h0002_0000;
   localparam logic [31:0] R_48B    = 32'h0003_0000;
   localparam logic [31:0] T_READ   = 32'h0000_0010;
   localparam logic [31:0] T_BLKCNT = 32'h0000_0002;

   localparam logic [31:0] W_GO_IDLE   = 32'd0 << 24;
   localparam logic [31:0] W_ALL_CID   = (32'd2 << 24) | R_136 | F_CRCCHK;
   localparam logic [31:0] W_SEND_RCA  = (32'd3 << 24) | R_48 | F_CRCCHK;
   localparam logic [31:0] W_SELECT    = (32'd7 << 24) | R_48B | F_CRCCHK;
   localparam logic [31:0] W_IF_COND   = (32'd8 << 24) | R_48 | F_CRCCHK | F_IXCHK;
   localparam logic [31:0] W_BLOCKLEN  = (32'd16 << 24) | R_48 | F_CRCCHK;
   localparam logic [31:0] W_READ_ONE  = (32'd17 << 24) | R_48 | F_CRCCHK | F_DATA
                                         | T_READ | T_BLKCNT;
   localparam logic [31:0] W_WRITE_ONE = (32'd24 << 24) | R_48 | F_CRCCHK | F_DATA
                                         | T_BLKCNT;
   localparam logic [31:0] W_APP_CMD   = (32'd55 << 24) | R_48 | F_CRCCHK;
   localparam logic [31:0] W_OP_COND   = (32'd41 << 24) | R_48;

   localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
   localparam logic [11:0] IF_COND_ECHO = 12'h1AA;
   localparam logic [31:0] OCR_WINDOW   = 32'h00FF_8000;
   localparam logic [9:0]  DIV_LIMIT    = 10'h3FF;
   localparam longint      BASE_LOW     = 1_000_000;
   localparam longint      BASE_HIGH    = 1_000_000_000;
   localparam longint      BASE_DEFAULT = 41_666_666;

   typedef enum logic [4:0] {
      SQ_IDLE, SQ_HRST, SQ_CLK_ID, SQ_CMD0, SQ_CMD8, SQ_CMD55, SQ_ACMD41, SQ_RETRY,
      SQ_CMD2, SQ_CMD3, SQ_CLK_WORK, SQ_CMD7, SQ_CMD16, SQ_READY, SQ_ACCESS, SQ_FAILED
   } seq_phase_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] cmd_word;
      logic [31:0] cmd_arg;
      logic [9:0]  divider;
      logic [2:0]  err;
      logic [5:0]  fail_idx;
      logic        line_reset;
      logic        blk_addr;
      logic [15:0] rca;
   } card_action_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [2:0]   req_tuser = 3'd0;    // req_type
   logic [71:0]  req_tdata = '0;      // resp_word, is_write, block_lba, zero pad
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [2:0]   rsp_tuser;           // action
   logic [103:0] rsp_tdata;           // cmd_word, cmd_arg, clock_divider, error_code,
                                      // failed_cmd, cmd_line_reset, block_addressed,
                                      // card_rca, zero pad
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   sd_card_init_sequencer dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // sequencer model state and its copy of the registers
   seq_phase_type   card_phase = SQ_IDLE;
   logic            card_v2 = 1'b0;
   logic            card_hc = 1'b0;
   logic [15:0]     card_rca = '0;
   logic [9:0]      power_tries = '0;
   logic [5:0]      pending_idx = '0;
   logic [9:0]      card_div = '0;
   logic [29:0]     cfg_base_hz = 30'd41_666_666;
   logic [18:0]     cfg_ident_hz = 19'd400_000;
   logic [25:0]     cfg_work_hz = 26'd25_000_000;
   logic [9:0]      cfg_max_tries = 10'd1000;
   card_action_type step_res;

   card_action_type expected_actions[$];
   logic [2:0]      last_action;
   int              mismatch_count = 0;
   int              events_sent = 0;
   int              results_checked = 0;
   int              settings_used = 0;
   int              act_seen[8];
   bit              req_fast = 1'b0;
   bit              rsp_fast = 1'b0;
   int              rsp_hold = 0;

   function automatic logic [9:0] divider_for(logic [31:0] hz);
      longint base, den, d;
      base = cfg_base_hz;
      if (base < BASE_LOW || base > BASE_HIGH) base = BASE_DEFAULT;
      if (hz == 0) return DIV_LIMIT;
      den = 2 * longint'(hz);
      d = (base + den - 1) / den;
      if (d < 1) d = 1;
      if (d > DIV_LIMIT) d = DIV_LIMIT;
      return d[9:0];
   endfunction

   function automatic void emit_issue(logic [31:0] w, logic [31:0] a, seq_phase_type nx);
      step_res.action = ACT_ISSUE;
      step_res.cmd_word = w;
      step_res.cmd_arg = a;
      pending_idx = w[29:24];
      card_phase = nx;
   endfunction

   function automatic void emit_clock(logic [31:0] hz, seq_phase_type nx);
      card_div = divider_for(hz);
      step_res.action = ACT_SET_CLOCK;
      card_phase = nx;
   endfunction

   function automatic void emit_fail(logic [2:0] code, logic clr, seq_phase_type nx);
      step_res.action = ACT_FAILED;
      step_res.err = code;
      step_res.fail_idx = pending_idx;
      step_res.line_reset = clr;
      card_phase = nx;
   endfunction

   function automatic void emit_app_prefix();
      emit_issue(W_APP_CMD, {card_rca, 16'h0}, SQ_CMD55);
   endfunction

   // advances the model by one event and leaves the expected action in step_res
   function automatic void sequencer_step(logic [2:0] kind, logic [31:0] resp, logic wr,
                                          logic [31:0] lba);
      logic in_cmd;
      logic [31:0] addr;
      step_res = '0;
      in_cmd = (card_phase == SQ_CMD0) || (card_phase == SQ_CMD8) ||
               (card_phase == SQ_CMD55) || (card_phase == SQ_ACMD41) ||
               (card_phase == SQ_CMD2) || (card_phase == SQ_CMD3) ||
               (card_phase == SQ_CMD7) || (card_phase == SQ_CMD16);
      case (kind)
         REQ_START: begin
            card_v2 = 1'b0;
            card_hc = 1'b0;
            card_rca = '0;
            power_tries = '0;
            pending_idx = '0;
            card_phase = SQ_HRST;
            step_res.action = ACT_RESET_HOST;
         end
         REQ_HRST_DONE: begin
            if (card_phase == SQ_HRST) emit_clock(32'(cfg_ident_hz), SQ_CLK_ID);
         end
         REQ_CLK_STABLE: begin
            if (card_phase == SQ_CLK_ID) emit_issue(W_GO_IDLE, '0, SQ_CMD0);
            else if (card_phase == SQ_CLK_WORK) emit_issue(W_SELECT, {card_rca, 16'h0}, SQ_CMD7);
         end
         REQ_CMD_DONE: begin
            case (card_phase)
               SQ_CMD0: emit_issue(W_IF_COND, IF_COND_ARG, SQ_CMD8);
               SQ_CMD8: begin
                  card_v2 = (resp[11:0] == IF_COND_ECHO);
                  power_tries = '0;
                  emit_app_prefix();
               end
               SQ_CMD55: emit_issue(W_OP_COND, OCR_WINDOW | {1'b0, card_v2, 30'h0}, SQ_ACMD41);
               SQ_ACMD41: begin
                  power_tries = power_tries + 10'd1;
                  if (resp[31]) begin
                     card_hc = resp[30];
                     emit_issue(W_ALL_CID, '0, SQ_CMD2);
                  end else if (power_tries >= cfg_max_tries) begin
                     emit_fail(ERR_POWER, 1'b0, SQ_FAILED);
                  end else begin
                     step_res.action = ACT_WAIT_RETRY;
                     card_phase = SQ_RETRY;
                  end
               end
               SQ_CMD2: emit_issue(W_SEND_RCA, '0, SQ_CMD3);
               SQ_CMD3: begin
                  card_rca = resp[31:16];
                  emit_clock(32'(cfg_work_hz), SQ_CLK_WORK);
               end
               SQ_CMD7: emit_issue(W_BLOCKLEN, 32'(SECTOR_BYTES), SQ_CMD16);
               SQ_CMD16: begin
                  step_res.action = ACT_READY;
                  card_phase = SQ_READY;
               end
               SQ_ACCESS: begin
                  step_res.action = ACT_DONE;
                  card_phase = SQ_READY;
               end
               default: ;
            endcase
         end
         REQ_FAILURE: begin
            // a failed CMD8 only marks the card as v1 and carries on
            if (card_phase == SQ_CMD8) begin
               card_v2 = 1'b0;
               power_tries = '0;
               emit_app_prefix();
               step_res.line_reset = 1'b1;
            end else if (in_cmd) begin
               emit_fail(ERR_CMD, 1'b1, SQ_FAILED);
            end else if (card_phase == SQ_ACCESS) begin
               emit_fail(ERR_CMD, 1'b1, SQ_READY);
            end else if (card_phase == SQ_HRST) begin
               emit_fail(ERR_CMD, 1'b0, SQ_FAILED);
            end else if (card_phase == SQ_CLK_ID || card_phase == SQ_CLK_WORK) begin
               emit_fail(ERR_CLOCK, 1'b0, SQ_FAILED);
            end
         end
         REQ_RETRY_TICK: begin
            if (card_phase == SQ_RETRY) emit_app_prefix();
         end
         REQ_ACCESS: begin
            if (card_phase == SQ_READY) begin
               addr = card_hc ? lba : (lba << 9);
               emit_issue(wr ? W_WRITE_ONE : W_READ_ONE, addr, SQ_ACCESS);
            end else begin
               step_res.action = ACT_FAILED;
               step_res.err = ERR_NOT_INIT;
            end
         end
         default: ;
      endcase
      step_res.divider = card_div;
      step_res.blk_addr = card_hc;
      step_res.rca = card_rca;
   endfunction

   task automatic send_event(logic [2:0] kind, logic [31:0] resp, logic wr, logic [31:0] lba);
      int gap;
      gap = req_fast ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {7'h0, lba, wr, resp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sequencer_step(kind, resp, wr, lba);
      expected_actions.push_back(step_res);
      last_action = step_res.action;
      events_sent++;
   endtask

   // hold the sender until every result is back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      logic [31:0] kept;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_BASE_HZ: begin
            cfg_base_hz = val[29:0];
            kept = 32'(cfg_base_hz);
         end
         CSR_IDENT_HZ: begin
            cfg_ident_hz = val[18:0];
            kept = 32'(cfg_ident_hz);
         end
         CSR_WORK_HZ: begin
            cfg_work_hz = val[25:0];
            kept = 32'(cfg_work_hz);
         end
         default: begin
            cfg_max_tries = val[9:0];
            kept = 32'(cfg_max_tries);
         end
      endcase
      // read back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== kept) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("register %0d reads %h, expected %h", idx, csr_prdata, kept);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_config(logic [31:0] base, logic [31:0] ident, logic [31:0] work,
                                 logic [31:0] tries);
      drain();
      csr_write(CSR_BASE_HZ, base);
      csr_write(CSR_IDENT_HZ, ident);
      csr_write(CSR_WORK_HZ, work);
      csr_write(CSR_MAX_TRIES, tries);
      settings_used++;
   endtask

   // picks the event that moves bring-up forward, with random payload
   task automatic send_next_step();
      logic [2:0] kind;
      logic [31:0] resp;
      resp = $urandom;
      kind = REQ_CMD_DONE;
      case (card_phase)
         SQ_IDLE, SQ_FAILED: kind = REQ_START;
         SQ_HRST: kind = ($urandom_range(0, 29) == 0) ? REQ_FAILURE : REQ_HRST_DONE;
         SQ_CLK_ID, SQ_CLK_WORK:
            kind = ($urandom_range(0, 29) == 0) ? REQ_FAILURE : REQ_CLK_STABLE;
         SQ_CMD8: begin
            if ($urandom_range(0, 9) == 0) kind = REQ_FAILURE;
            else if ($urandom_range(0, 3) != 0) resp[11:0] = IF_COND_ECHO;
         end
         SQ_ACMD41: resp[31] = ($urandom_range(0, 9) < 3);
         SQ_RETRY: kind = REQ_RETRY_TICK;
         SQ_READY: kind = REQ_ACCESS;
         SQ_ACCESS: kind = ($urandom_range(0, 6) == 0) ? REQ_FAILURE : REQ_CMD_DONE;
         default: kind = ($urandom_range(0, 49) == 0) ? REQ_FAILURE : REQ_CMD_DONE;
      endcase
      send_event(kind, resp, 1'($urandom_range(0, 1)), $urandom);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("result %0d: %s expected %h, got %h", results_checked, name, want, got);
      end
   endtask

   // result side stall: a fresh wait is drawn after every accepted word
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         rsp_hold = rsp_fast ? 0 : $urandom_range(0, 6);
         rsp_tready <= (rsp_hold == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold = rsp_hold - 1;
         rsp_tready <= (rsp_hold == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      card_action_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_actions.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result word with no event waiting: action %0d", rsp_tuser);
         end else begin
            want = expected_actions.pop_front();
            check_field("action", 32'(want.action), 32'(rsp_tuser));
            check_field("cmd_word", want.cmd_word, rsp_tdata[31:0]);
            check_field("cmd_arg", want.cmd_arg, rsp_tdata[63:32]);
            check_field("clock_divider", 32'(want.divider), 32'(rsp_tdata[73:64]));
            check_field("error_code", 32'(want.err), 32'(rsp_tdata[76:74]));
            check_field("failed_cmd", 32'(want.fail_idx), 32'(rsp_tdata[82:77]));
            check_field("cmd_line_reset", 32'(want.line_reset), 32'(rsp_tdata[83]));
            check_field("block_addressed", 32'(want.blk_addr), 32'(rsp_tdata[84]));
            check_field("card_rca", 32'(want.rca), 32'(rsp_tdata[100:85]));
            check_field("pad", 32'h0, 32'(rsp_tdata[103:101]));
            act_seen[want.action]++;
            results_checked++;
         end
      end
   end

   task automatic test_idle_events();
      send_event(REQ_ACCESS, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
      send_event(REQ_RSVD, '0, 1'b0, '0);
      send_event(REQ_RETRY_TICK, $urandom, 1'b0, $urandom);
   endtask

   task automatic test_bring_up_and_access();
      send_event(REQ_START, '0, 1'b0, '0);
      send_event(REQ_HRST_DONE, '0, 1'b0, '0);
      send_event(REQ_CLK_STABLE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_FAILURE, '0, 1'b0, '0);            // CMD8 fails: v1 card
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, 32'h0, 1'b0, '0);        // ACMD41 busy
      send_event(REQ_RETRY_TICK, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, 32'hC000_0000, 1'b0, '0); // ready, high capacity
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, 32'hFFFF_FFFF, 1'b0, '0); // RCA all ones
      send_event(REQ_CLK_STABLE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_ACCESS, '0, 1'b1, 32'hFFFF_FFFF);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_ACCESS, '0, 1'b0, 32'h0);
      send_event(REQ_FAILURE, '0, 1'b0, '0);            // access fails, back to ready
   endtask

   // base above range falls back, zero ident clock, try limit of zero
   task automatic test_failure_paths();
      program_config(32'd1_000_000_001, 32'd0, 32'd25_000_000, 32'd0);
      send_event(REQ_START, '0, 1'b0, '0);
      send_event(REQ_FAILURE, '0, 1'b0, '0);
      send_event(REQ_START, '0, 1'b0, '0);
      send_event(REQ_HRST_DONE, '0, 1'b0, '0);
      send_event(REQ_FAILURE, '0, 1'b0, '0);
      send_event(REQ_START, '0, 1'b0, '0);
      send_event(REQ_HRST_DONE, '0, 1'b0, '0);
      send_event(REQ_CLK_STABLE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, 32'h0000_01AA, 1'b0, '0);
      send_event(REQ_CMD_DONE, '0, 1'b0, '0);
      send_event(REQ_CMD_DONE, 32'h0, 1'b0, '0);        // power-up timeout
   endtask

   task automatic test_random_traffic();
      int useful, since_cfg, setting, pick;
      useful = 0;
      since_cfg = 160;
      setting = 0;
      while (useful < RANDOM_ITEMS) begin
         if (since_cfg >= 160) begin
            since_cfg = 0;
            case (setting)
               0: program_config(32'd1_000_000, 32'd100_000, 32'd400_000, 32'd1);
               1: program_config(32'd1_000_000_000, 32'd400_000, 32'd50_000_000, 32'd1000);
               2: program_config('1, '1, '1, '1);
               3: program_config(32'd0, 32'd0, 32'd0, 32'd0);
               default: program_config(
                  ($urandom_range(0, 4) != 0) ? $urandom_range(1_000_000, 1_000_000_000)
                                              : $urandom,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(100_000, 400_000) : $urandom,
                  ($urandom_range(0, 4) != 0) ? $urandom_range(400_000, 50_000_000)
                                              : $urandom,
                  ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom);
            endcase
            setting++;
            req_fast = ($urandom_range(0, 3) == 0);
            rsp_fast = ($urandom_range(0, 3) == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 84) send_next_step();
         else if (pick < 90) send_event(REQ_START, $urandom, 1'($urandom_range(0, 1)), $urandom);
         else send_event(3'($urandom_range(0, 7)), $urandom, 1'($urandom_range(0, 1)), $urandom);
         if (last_action != ACT_NONE) begin
            useful++;
            since_cfg++;
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_events();
      test_bring_up_and_access();
      test_failure_paths();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      $display("covered %0d events and %0d results over %0d register settings",
               events_sent, results_checked, settings_used);
      $display("  %0d clock changes, %0d ready, %0d failures, %0d accesses, %0d ignored",
               act_seen[ACT_SET_CLOCK], act_seen[ACT_READY], act_seen[ACT_FAILED],
               act_seen[ACT_DONE], act_seen[ACT_NONE]);
      if (mismatch_count == 0 && expected_actions.size() == 0) begin
         $display("sd_card_init_sequencer regression: pass");
      end else begin
         $display("  %0d mismatches", mismatch_count);
         $display("sd_card_init_sequencer regression: fail");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("timeout with %0d results outstanding", expected_actions.size());
      $display("sd_card_init_sequencer regression: fail");
      $finish;
   end

endmodule
